FILE: rtl/mexp_pkg.sv
`default_nettype none
package mexp_pkg;

  localparam int WORD_BITS    = 32;
  localparam int IDX_BITS     = $clog2(WORD_BITS);
  localparam int CNT_BITS     = $clog2(WORD_BITS + 1);
  localparam int TDATA_BITS   = ((WORD_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_SQUARE = 2'd1,
    OP_MULT   = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    cap_in;
    logic    acc_one;
    logic    mul_start;
    mul_op_t mul_op;
    logic    idx_init;
    logic    idx_dec;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic ebit;
    logic idx_zero;
    logic ezero;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/mexp_modmul.sv
`default_nettype none
// Shift-and-add modular multiplier, one bit of b per cycle, msb first.
// A modulus of zero stands for 2^WORD_BITS.
module mexp_modmul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mexp_pkg::WORD_BITS-1:0] a,
  input  wire logic [mexp_pkg::WORD_BITS-1:0] b,
  input  wire logic [mexp_pkg::WORD_BITS-1:0] m,
  output logic      [mexp_pkg::WORD_BITS-1:0] result,
  output logic                               busy,
  output logic                               done
);
  import mexp_pkg::*;

  logic [WORD_BITS-1:0] a_reg;
  logic [WORD_BITS-1:0] b_reg;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] r_next;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS:0]   mx;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   dbl_red;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   sum_red;

  assign mx = {(m == '0), m};

  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= mx) ? dbl - mx : dbl;
    sum     = {1'b0, dbl_red[WORD_BITS-1:0]} + {1'b0, a_reg};
    sum_red = (sum >= mx) ? sum - mx : sum;
    r_next  = b_reg[WORD_BITS-1] ? sum_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
  end

  assign busy   = (cnt != '0);
  assign result = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_BITS'(1));
      if (start) begin
        cnt <= CNT_BITS'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      r     <= '0;
    end else if (busy) begin
      b_reg <= {b_reg[WORD_BITS-2:0], 1'b0};
      r     <= r_next;
    end
  end

  a_res_below_mod: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, r} < mx))
    else $error("modular product not below modulus");

endmodule
`default_nettype wire

FILE: rtl/mexp_datapath.sv
`default_nettype none
module mexp_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [mexp_pkg::WORD_BITS-1:0]    cfg_data,
  input  wire logic [mexp_pkg::WORD_BITS-1:0]    in_value,
  input  wire mexp_pkg::ctrl_cmd_t              cmd,
  output mexp_pkg::dp_status_t                  st,
  output logic      [mexp_pkg::WORD_BITS-1:0]    out_value
);
  import mexp_pkg::*;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] cipher;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] acc;
  logic [IDX_BITS-1:0]  idx;
  mul_op_t              op_reg;
  logic [WORD_BITS-1:0] one_m;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS-1:0] mul_b;
  logic [WORD_BITS-1:0] product;
  logic                 mul_busy;
  logic                 mul_done;

  // 1 mod m; reduction of the input is done as one_m * cipher
  assign one_m = WORD_BITS'(modulus != WORD_BITS'(1));

  always_comb begin
    unique case (cmd.mul_op)
      OP_REDUCE: begin
        mul_a = one_m;
        mul_b = cipher;
      end
      OP_MULT: begin
        mul_a = acc;
        mul_b = base;
      end
      default: begin
        mul_a = acc;
        mul_b = acc;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus),
    .result (product),
    .busy   (mul_busy),
    .done   (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WORD_BITS'(1);
      exponent <= WORD_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == REG_EXPONENT) begin
        exponent <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) cipher <= in_value;
    if (cmd.mul_start) op_reg <= cmd.mul_op;
    if (cmd.acc_one) begin
      acc <= WORD_BITS'(1);
    end else if (mul_done) begin
      acc <= product;
      if (op_reg == OP_REDUCE) base <= product;
    end
    if (cmd.idx_init) begin
      idx <= IDX_BITS'(WORD_BITS - 1);
    end else if (cmd.idx_dec) begin
      idx <= idx - IDX_BITS'(1);
    end
    if (cmd.out_load) out_value <= acc;
  end

  assign st.mul_busy = mul_busy;
  assign st.mul_done = mul_done;
  assign st.ebit     = exponent[idx];
  assign st.idx_zero = (idx == '0);
  assign st.ezero    = (exponent == '0);

endmodule
`default_nettype wire

FILE: rtl/mexp_ctrl.sv
`default_nettype none
module mexp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output mexp_pkg::ctrl_cmd_t       cmd,
  input  wire mexp_pkg::dp_status_t st
);
  import mexp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOAD    = 8'b0000_0010,
    S_REDUCE  = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_SQUARE  = 8'b0001_0000,
    S_SQ_DONE = 8'b0010_0000,
    S_MULT    = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = OP_SQUARE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.ezero) begin
          cmd.acc_one = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_REDUCE;
          cmd.idx_init  = 1'b1;
          state_next    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (st.mul_done) state_next = S_SCAN;
      end
      // skip leading zero bits of the exponent
      S_SCAN: begin
        if (!st.ebit) begin
          cmd.idx_dec = 1'b1;
        end else if (st.idx_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_dec   = 1'b1;
          cmd.mul_start = 1'b1;
          state_next    = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (st.mul_done) state_next = S_SQ_DONE;
      end
      S_SQ_DONE: begin
        if (st.ebit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_MULT;
          state_next    = S_MULT;
        end else if (st.idx_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_dec   = 1'b1;
          cmd.mul_start = 1'b1;
          state_next    = S_SQUARE;
        end
      end
      S_MULT: begin
        if (st.mul_done) begin
          if (st.idx_zero) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !st.mul_busy)
    else $error("multiply started while unit busy");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    st.mul_done |-> (state == S_REDUCE || state == S_SQUARE || state == S_MULT))
    else $error("multiply finished in an unexpected state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !cmd.out_load)
    else $error("result overwritten before transaction");

endmodule
`default_nettype wire

FILE: rtl/modular_exponentiation_unit.sv
`default_nettype none
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   cipher_value
// m_axis    out        m_axis_tvalid/m_axis_tready   plain_value
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// One item takes one modular multiply for the reduction of the
// input, then one squaring per exponent bit below the top set bit and one
// multiply per set bit below it, plus scan steps over the exponent bits.
// The multiplier is bit-serial (one bit per cycle).
// Exponent zero returns 1. Reset sets modulus and exponent to 1.
// A new item is taken while the previous result waits on m_axis.
module modular_exponentiation_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [mexp_pkg::TDATA_BITS-1:0]    s_axis_tdata,  // [31:0] cipher_value
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [mexp_pkg::TDATA_BITS-1:0]    m_axis_tdata,  // [31:0] plain_value
  input  wire logic                              cfg_we,
  input  wire logic [mexp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [mexp_pkg::WORD_BITS-1:0]     cfg_data
);
  import mexp_pkg::*;

  ctrl_cmd_t            cmd;
  dp_status_t           st;
  logic [WORD_BITS-1:0] out_value;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .cmd      (cmd),
    .st       (st)
  );

  mexp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_value  (s_axis_tdata[WORD_BITS-1:0]),
    .cmd       (cmd),
    .st        (st),
    .out_value (out_value)
  );

  assign m_axis_tdata = TDATA_BITS'(out_value);

endmodule
`default_nettype wire
